// File: sv/sac_pkg.sv
package sac_pkg;

  // configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_BLK_OFFSET = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_INDEX_BITS = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS       = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_POLICY     = 8'd3;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  localparam int CntW = 32;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
  } sac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } sac_sts_t;

endpackage

// File: sv/sac_ctrl.sv
module sac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sac_pkg::sac_sts_t sts_i,
  output sac_pkg::sac_cmd_t cmd_o,
  output logic              busy_o
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } sac_state_e;

  sac_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: sv/sac_dp.sv
module sac_dp #(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sac_pkg::sac_cmd_t            cmd_i,
  output sac_pkg::sac_sts_t            sts_o,
  input  logic                         cfg_we_i,
  input  logic [sac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sac_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         req_type_i,
  input  logic [ADDR_BITS-1:0]         address_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic                         memory_read_o,
  output logic                         memory_write_o,
  output logic [sac_pkg::CntW-1:0]     hit_total_o,
  output logic [sac_pkg::CntW-1:0]     miss_total_o,
  output logic [sac_pkg::CntW-1:0]     read_total_o,
  output logic [sac_pkg::CntW-1:0]     write_total_o
);

  localparam int SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int IbMax = $clog2(MAX_SETS + 1) - 1;
  localparam int WayW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WcntW = $clog2(MAX_WAYS + 1);
  localparam int TagsW = MAX_WAYS * ADDR_BITS;
  localparam int RowW  = TagsW + MAX_WAYS;
  localparam int ShW   = 7;

  typedef logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row_t;

  // configuration
  logic [4:0] blk_off_q;
  logic [3:0] index_bits_q;
  logic [3:0] ways_q;
  logic       policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_off_q    <= 5'd0;
      index_bits_q <= 4'd0;
      ways_q       <= 4'd8;
      policy_q     <= sac_pkg::POLICY_FIFO;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sac_pkg::CFG_BLK_OFFSET: blk_off_q    <= cfg_data_i;
        sac_pkg::CFG_INDEX_BITS: index_bits_q <= cfg_data_i[3:0];
        sac_pkg::CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        sac_pkg::CFG_POLICY:     policy_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // address split
  logic [3:0]           ib_eff;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [ADDR_BITS-1:0] set_mask;
  logic [ADDR_BITS-1:0] set_full;
  logic [SetW-1:0]      set_idx;
  logic [ADDR_BITS-1:0] tag_in;

  assign ib_eff   = (int'(index_bits_q) > IbMax) ? 4'(IbMax) : index_bits_q;
  assign addr_sh  = address_i >> blk_off_q;
  assign set_mask = (ADDR_BITS'(1) << ib_eff) - ADDR_BITS'(1);
  assign set_full = addr_sh & set_mask;
  assign set_idx  = SetW'(set_full);
  assign tag_in   = address_i >> (ShW'(blk_off_q) + ShW'(ib_eff));

  logic [SetW-1:0]      set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 wr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q <= set_idx;
      tag_q <= tag_in;
      wr_q  <= req_type_i;
    end
  end

  // clearing sweep after reset
  logic [SetW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == SetW'(MAX_SETS - 1));

  // set memory: one row holds valid bits and tags of all ways
  logic [RowW-1:0] mem [MAX_SETS];
  logic [RowW-1:0] rdata_q;
  logic [RowW-1:0] wdata;
  logic [SetW-1:0] waddr;
  logic            we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rdata_q <= mem[set_idx];
    end
  end

  // lookup and replacement
  tag_row_t            rd_tags;
  tag_row_t            up_tags;
  tag_row_t            nt;
  logic [MAX_WAYS-1:0] rd_vld;
  logic [MAX_WAYS-1:0] nv;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [WcntW-1:0]    ways_eff;
  logic [WayW-1:0]     ways_last;
  logic [WayW-1:0]     pos;
  logic [WayW-1:0]     last;
  logic [WayW-1:0]     fe;
  logic                hit;
  logic                any_empty;
  logic                run;

  assign rd_tags   = rdata_q[TagsW-1:0];
  assign rd_vld    = rdata_q[RowW-1 -: MAX_WAYS];
  assign up_tags   = rd_tags >> ADDR_BITS;
  assign ways_eff  = (ways_q == 4'd0) ? WcntW'(1) :
                     (int'(ways_q) > MAX_WAYS) ? WcntW'(MAX_WAYS) : WcntW'(ways_q);
  assign ways_last = WayW'(ways_eff - 1'b1);

  always_comb begin
    hit       = 1'b0;
    pos       = '0;
    any_empty = 1'b0;
    fe        = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w < int'(ways_eff));
      match[w]  = in_use[w] && rd_vld[w] && (rd_tags[w] == tag_q);
      if (!hit && match[w]) begin
        hit = 1'b1;
        pos = WayW'(w);
      end
      if (!any_empty && in_use[w] && !rd_vld[w]) begin
        any_empty = 1'b1;
        fe        = WayW'(w);
      end
    end
  end

  // end of the valid run that starts at the hit way
  always_comb begin
    last = pos;
    run  = 1'b1;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WayW'(w) > pos) begin
        if (run && in_use[w] && rd_vld[w]) begin
          last = WayW'(w);
        end else begin
          run = 1'b0;
        end
      end
    end
  end

  always_comb begin
    nt = rd_tags;
    nv = rd_vld;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (hit) begin
        if (policy_q == sac_pkg::POLICY_LRU) begin
          if (WayW'(w) >= pos && WayW'(w) < last) begin
            nt[w] = up_tags[w];
          end else if (WayW'(w) == last) begin
            nt[w] = tag_q;
          end
        end
      end else if (any_empty) begin
        if (WayW'(w) == fe) begin
          nt[w] = tag_q;
          nv[w] = 1'b1;
        end
      end else begin
        // full set: drop the oldest way and insert at the newest
        if (WayW'(w) < ways_last) begin
          nt[w] = up_tags[w];
        end else if (WayW'(w) == ways_last) begin
          nt[w] = tag_q;
          nv[w] = 1'b1;
        end
      end
    end
  end

  assign we    = cmd_i.clear || cmd_i.update;
  assign waddr = cmd_i.clear ? clr_cnt_q : set_q;
  assign wdata = cmd_i.clear ? '0 : {nv, nt};

  // counters and result word
  logic [sac_pkg::CntW-1:0] hit_cnt_q, miss_cnt_q, rd_cnt_q, wr_cnt_q;
  logic                     done_q;
  logic                     hit_q, mrd_q, mwr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      rd_cnt_q   <= '0;
      wr_cnt_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.update) begin
        if (hit && hit_cnt_q != '1) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end
        if (!hit && miss_cnt_q != '1) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
        if (!hit && rd_cnt_q != '1) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
        if (wr_q && wr_cnt_q != '1) begin
          wr_cnt_q <= wr_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_q <= hit;
      mrd_q <= !hit;
      mwr_q <= wr_q;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign memory_read_o  = mrd_q;
  assign memory_write_o = mwr_q;
  assign hit_total_o    = hit_cnt_q;
  assign miss_total_o   = miss_cnt_q;
  assign read_total_o   = rd_cnt_q;
  assign write_total_o  = wr_cnt_q;

endmodule

// File: sv/set_assoc_cache_tag_sim_core.sv
// Tag-only set-associative cache simulator with fifo or lru replacement. After reset the
// block sweeps the set memory to mark every way invalid, with busy_o high; configuration
// writes are taken at any time. An access is taken when start_i is high and busy_o is low,
// and runs in a read step and an update step: the read step fetches the set's row from the
// set memory, the update step compares the tags and writes the reordered row back through
// its single write port. The result is registered in the update step and shows on the
// outputs with done_o high for one cycle; the receiver cannot stall it. Counters saturate.
module set_assoc_cache_tag_sim_core #(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [ADDR_BITS-1:0]         address_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sac_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic                         memory_read_o,
  output logic                         memory_write_o,
  output logic [sac_pkg::CntW-1:0]     hit_total_o,
  output logic [sac_pkg::CntW-1:0]     miss_total_o,
  output logic [sac_pkg::CntW-1:0]     read_total_o,
  output logic [sac_pkg::CntW-1:0]     write_total_o
);

  sac_pkg::sac_cmd_t cmd;
  sac_pkg::sac_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sac_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  sac_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .memory_read_o (memory_read_o),
    .memory_write_o(memory_write_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .read_total_o  (read_total_o),
    .write_total_o (write_total_o)
  );

endmodule

// File: sv/sac_chk.sv
module sac_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic                     hit_o,
  input logic                     memory_read_o,
  input logic                     memory_write_o,
  input logic [sac_pkg::CntW-1:0] write_total_o
);

  // each taken access produces a result word after its read and update steps
  a_word_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("missing result word");

  a_busy_while_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("access not held busy");

  a_hit_xor_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o != memory_read_o))
    else $error("hit and memory read disagree");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && memory_write_o && ($past(write_total_o) != '1))
      |-> (write_total_o == $past(write_total_o) + 1'b1))
    else $error("write total not advanced");

endmodule

bind set_assoc_cache_tag_sim_core sac_chk u_sac_chk (.*);

// File: test/set_assoc_cache_tag_sim_core_test.sv
module set_assoc_cache_tag_sim_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSets    = 1024;
  localparam int MaxWays    = 8;
  localparam int AddrBits   = 48;
  localparam int StallLimit = 6000;
  localparam int SegItems   = 155;
  localparam int CntW       = sac_pkg::CntW;
  localparam int IdxW       = sac_pkg::CfgIdxW;
  localparam int DataW      = sac_pkg::CfgDataW;

  typedef struct packed {
    logic            hit;
    logic            mem_read;
    logic            mem_write;
    logic [CntW-1:0] hits;
    logic [CntW-1:0] misses;
    logic [CntW-1:0] reads;
    logic [CntW-1:0] writes;
  } access_outcome_t;

  // tracks the tag arrays and counters, queues the outcome of every accepted access
  class cache_tag_board;
    bit [AddrBits-1:0] tags [MaxSets][MaxWays];
    bit                valid [MaxSets][MaxWays];
    bit [CntW-1:0]     hit_cnt, miss_cnt, read_cnt, write_cnt;
    bit [4:0]          blk_off;
    bit [3:0]          index_bits;
    bit [3:0]          ways_cfg;
    logic              policy;
    access_outcome_t   pending_outcomes [$];
    int unsigned       mismatches;

    function new();
      foreach (valid[r, w]) begin
        valid[r][w] = 1'b0;
        tags[r][w]  = '0;
      end
      hit_cnt    = '0;
      miss_cnt   = '0;
      read_cnt   = '0;
      write_cnt  = '0;
      blk_off    = 5'd0;
      index_bits = 4'd0;
      ways_cfg   = 4'd8;
      policy     = sac_pkg::POLICY_FIFO;
      mismatches = 0;
    endfunction

    function bit [CntW-1:0] sat_inc(bit [CntW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    // index bits beyond what MaxSets can hold are dropped
    function int index_width();
      int b;
      b = int'(index_bits);
      while (b > 0 && (1 << b) > MaxSets) b--;
      return b;
    endfunction

    function int way_count();
      int w;
      w = int'(ways_cfg);
      if (w == 0) w = 1;
      if (w > MaxWays) w = MaxWays;
      return w;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] val);
      case (idx)
        sac_pkg::CFG_BLK_OFFSET: blk_off    = val;
        sac_pkg::CFG_INDEX_BITS: index_bits = val[3:0];
        sac_pkg::CFG_WAYS:       ways_cfg   = val[3:0];
        sac_pkg::CFG_POLICY:     policy     = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void note_access(bit is_wr, bit [AddrBits-1:0] addr);
      access_outcome_t   e;
      int                ob, ib, nw, row, pos, last;
      bit [AddrBits-1:0] tag;
      bit                found, placed;
      ob    = int'(blk_off);
      ib    = index_width();
      nw    = way_count();
      row   = int'((addr >> ob) & ((AddrBits'(1) << ib) - 1));
      tag   = addr >> (ob + ib);
      found = 1'b0;
      pos   = 0;
      if (is_wr) write_cnt = sat_inc(write_cnt);
      for (int w = 0; w < nw; w++) begin
        if (!found && valid[row][w] && tags[row][w] == tag) begin
          found = 1'b1;
          pos   = w;
        end
      end
      if (found) begin
        hit_cnt = sat_inc(hit_cnt);
        if (policy == sac_pkg::POLICY_LRU) begin
          // move the tag up to the newest valid slot
          last = pos;
          while (last + 1 < nw && valid[row][last+1]) last++;
          for (int w = pos; w < last; w++) tags[row][w] = tags[row][w+1];
          tags[row][last] = tag;
        end
      end else begin
        miss_cnt = sat_inc(miss_cnt);
        read_cnt = sat_inc(read_cnt);
        placed   = 1'b0;
        for (int w = 0; w < nw; w++) begin
          if (!placed && !valid[row][w]) begin
            tags[row][w]  = tag;
            valid[row][w] = 1'b1;
            placed        = 1'b1;
          end
        end
        if (!placed) begin
          // set full: drop the oldest, shift down, insert at the newest
          for (int w = 1; w < nw; w++) tags[row][w-1] = tags[row][w];
          tags[row][nw-1]  = tag;
          valid[row][nw-1] = 1'b1;
        end
      end
      e.hit       = found;
      e.mem_read  = !found;
      e.mem_write = is_wr;
      e.hits      = hit_cnt;
      e.misses    = miss_cnt;
      e.reads     = read_cnt;
      e.writes    = write_cnt;
      pending_outcomes.push_back(e);
    endfunction

    function void check_result(access_outcome_t got);
      access_outcome_t e;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with no access outstanding", $time);
        return;
      end
      e = pending_outcomes.pop_front();
      if (got.hit !== e.hit || got.mem_read !== e.mem_read || got.mem_write !== e.mem_write ||
          got.hits !== e.hits || got.misses !== e.misses || got.reads !== e.reads ||
          got.writes !== e.writes) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result mismatch, expected hit %0b rd %0b wr %0b totals %0d/%0d/%0d/%0d,",
                    " got hit %0b rd %0b wr %0b totals %0d/%0d/%0d/%0d"}, $time,
                   e.hit, e.mem_read, e.mem_write, e.hits, e.misses, e.reads, e.writes,
                   got.hit, got.mem_read, got.mem_write, got.hits, got.misses, got.reads,
                   got.writes);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                req_type_i  = 1'b0;
  logic [AddrBits-1:0] address_i   = '0;
  logic                cfg_valid_i = 1'b0;
  logic [IdxW-1:0]     cfg_index_i = '0;
  logic [DataW-1:0]    cfg_data_i  = '0;
  logic                busy_o;
  logic                cfg_ready_o;
  logic                done_o;
  logic                hit_o;
  logic                memory_read_o;
  logic                memory_write_o;
  logic [CntW-1:0]     hit_total_o;
  logic [CntW-1:0]     miss_total_o;
  logic [CntW-1:0]     read_total_o;
  logic [CntW-1:0]     write_total_o;

  cache_tag_board board;
  int unsigned    quiet_cycles = 0;

  // geometry per random segment: offset bits, index bits, ways, policy
  int geo_ob   [12] = '{0, 16, 31, 5, 2, 6, 12, 0, 0, 0, 4, 9};
  int geo_ib   [12] = '{0, 10, 15, 3, 1, 4, 11, 2, 0, 0, 0, 7};
  int geo_ways [12] = '{1, 8, 15, 4, 0, 3, 9, 8, 0, 0, 2, 5};
  int geo_pol  [12] = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 0, 1, 1};

  set_assoc_cache_tag_sim_core #(
    .MAX_SETS (MaxSets),
    .MAX_WAYS (MaxWays),
    .ADDR_BITS(AddrBits)
  ) dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .req_type_i,
    .address_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .done_o,
    .hit_o,
    .memory_read_o,
    .memory_write_o,
    .hit_total_o,
    .miss_total_o,
    .read_total_o,
    .write_total_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(access_outcome_t'{hit_o, memory_read_o, memory_write_o, hit_total_o,
                                           miss_total_o, read_total_o, write_total_o});
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("set_assoc_cache_tag_sim_core_test: done, errors");
      $finish;
    end
  end

  // start stays high across back-to-back words, lowered only for a gap
  task automatic issue_access(input bit is_wr, input logic [AddrBits-1:0] addr,
                              input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= is_wr;
    address_i  <= addr;
    do @(posedge clk_i); while (busy_o);
    board.note_access(is_wr, addr);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
  endtask

  // only reprogram once every outstanding access has come back
  task automatic set_geometry(input int ob, input int ib, input int nw, input int pol);
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    write_reg(sac_pkg::CFG_BLK_OFFSET, DataW'(ob));
    write_reg(sac_pkg::CFG_INDEX_BITS, DataW'(ib));
    write_reg(sac_pkg::CFG_WAYS, DataW'(nw));
    write_reg(sac_pkg::CFG_POLICY, DataW'(pol));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int                  idle_pct, ob, ib, pool_size;
    logic [AddrBits-1:0] addr, off;
    logic [AddrBits-1:0] tag_pool [12];
    int unsigned         row_pool [4];
    board = new();
    for (int s = 8; s < 10; s++) begin
      geo_ob[s]   = $urandom_range(31);
      geo_ib[s]   = $urandom_range(15);
      geo_ways[s] = $urandom_range(15);
      geo_pol[s]  = $urandom_range(1);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: one set of eight ways, fifo; fill, then evict twice
    issue_access(1'b0, '0, 0);
    issue_access(1'b1, '0, 0);
    issue_access(1'b0, '1, 0);
    issue_access(1'b1, '1, 0);
    for (int t = 1; t <= 6; t++) issue_access(1'b0, AddrBits'(t), 0);
    issue_access(1'b1, AddrBits'(7), 0);
    issue_access(1'b0, '0, 0);
    issue_access(1'b0, AddrBits'(7), 0);

    // two-way lru: hits reorder the set, so the victim changes
    set_geometry(4, 2, 2, int'(sac_pkg::POLICY_LRU));
    issue_access(1'b0, AddrBits'((5 << 6) | (1 << 4) | 15), 0);
    issue_access(1'b1, AddrBits'((9 << 6) | (1 << 4)), 0);
    issue_access(1'b0, AddrBits'((5 << 6) | (1 << 4)), 0);
    issue_access(1'b0, AddrBits'((3 << 6) | (1 << 4) | 7), 0);
    issue_access(1'b1, AddrBits'((5 << 6) | (1 << 4) | 2), 0);
    issue_access(1'b0, AddrBits'((9 << 6) | (1 << 4)), 0);
    issue_access(1'b0, AddrBits'((5 << 6) | (1 << 4)), 0);

    // zero ways acts as one, index bits clamp, widest offset
    set_geometry(31, 15, 0, int'(sac_pkg::POLICY_FIFO));
    issue_access(1'b1, '1, 0);
    issue_access(1'b1, '1, 0);
    issue_access(1'b0, '0, 0);

    for (int s = 0; s < 12; s++) begin
      idle_pct = (s < 4) ? 9 : (s < 8) ? 46 : 0;
      set_geometry(geo_ob[s], geo_ib[s], geo_ways[s], geo_pol[s]);
      ob        = int'(board.blk_off);
      ib        = board.index_width();
      pool_size = board.way_count() + 1 + $urandom_range(3);
      for (int k = 0; k < pool_size; k++) begin
        tag_pool[k] = k[0] ? AddrBits'({$urandom, $urandom}) : AddrBits'($urandom_range(15));
      end
      for (int k = 0; k < 4; k++) row_pool[k] = $urandom & ((1 << ib) - 1);
      // mostly a few sets with a tag pool just over the ways, plus some stray addresses
      repeat (SegItems) begin
        if ($urandom_range(9) == 0) begin
          addr = AddrBits'({$urandom, $urandom});
        end else begin
          off  = AddrBits'({$urandom, $urandom}) & ((AddrBits'(1) << ob) - 1);
          addr = (tag_pool[$urandom_range(pool_size - 1)] << (ob + ib)) |
                 (AddrBits'(row_pool[$urandom_range(3)]) << ob) | off;
        end
        issue_access(1'($urandom_range(1)), addr, idle_pct);
      end
    end

    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("set_assoc_cache_tag_sim_core_test: done, clean");
    end else begin
      $display("set_assoc_cache_tag_sim_core_test: done, errors");
    end
    $finish;
  end

endmodule
